// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a clock, masked while reset is low.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, phrased as an implication from a trigger.
`define CHK_IMPLY(lbl, clk, rst_n, trig, cons, msg) \
    `CHK_ASSERT(lbl, clk, rst_n, (trig) |-> (cons), msg)

`endif

// ----- rtl/doeq_pkg.sv -----
// ----------------------------------------------------------------------------
// doeq_pkg
// Types and codes shared by the drop-oldest event queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package doeq_pkg;

    localparam int NW_W = 6;

    localparam logic [1:0] CMD_PUBLISH = 2'd0;
    localparam logic [1:0] CMD_PULL    = 2'd1;
    localparam logic [1:0] CMD_DRAIN   = 2'd2;

    localparam logic [1:0] ST_EVENT = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_NOFIT = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] event_type;
        logic [15:0] payload_len;
        logic [63:0] timestamp;
        logic [63:0] payload_word;
        logic        word_last;
        logic [31:0] remaining_budget;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] data_word;
        logic        word_final;
        logic [8:0]  event_bytes;
        logic [6:0]  queued_after;
    } rsp_t;

    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_EMPTY,
        SEL_NOFIT,
        SEL_DRAIN,
        SEL_WORD0,
        SEL_WORD1,
        SEL_PAYLOAD
    } out_sel_t;

    typedef struct packed {
        logic     take;
        out_sel_t sel;
        logic     fin;
        logic     pop;
        logic     rd_clr;
        logic     rd_inc;
    } ctl_cmd_t;

    typedef struct packed {
        logic            empty;
        logic            fits;
        logic            out_busy;
        logic [NW_W-1:0] nw;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/doeq_ctrl.sv -----
// ----------------------------------------------------------------------------
// doeq_ctrl
// Request sequencer: decodes pull and drain, checks fit, walks event words.
// ----------------------------------------------------------------------------
`default_nettype none

module doeq_ctrl
    import doeq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire logic [1:0] command,
    input  wire dp_stat_t stat,
    output ctl_cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_EMIT
    } state_t;

    state_t          state_reg, state_next;
    logic [NW_W-1:0] cnt_reg, cnt_next;
    logic            take;

    assign req_ready = (state_reg == S_IDLE) && !stat.out_busy;
    assign take      = req_valid && req_ready;

    always_comb
    begin
        cmd        = '0;
        cmd.sel    = SEL_NONE;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.take = take;
                if (take && command == CMD_PULL)
                begin
                    if (stat.empty)
                    begin
                        cmd.sel = SEL_EMPTY;
                        cmd.fin = 1'b1;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
                else if (take && command == CMD_DRAIN)
                begin
                    cmd.sel = SEL_DRAIN;
                    cmd.fin = 1'b1;
                end
            end
            S_CHECK:
            begin
                if (!stat.fits)
                begin
                    cmd.sel    = SEL_NOFIT;
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    // emit header word 0 and pop the head slot
                    cmd.sel    = SEL_WORD0;
                    cmd.pop    = 1'b1;
                    cmd.rd_clr = 1'b1;
                    cnt_next   = '0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    if (cnt_reg == '0)
                    begin
                        cmd.sel = SEL_WORD1;
                        cmd.fin = (stat.nw == '0);
                    end
                    else
                    begin
                        cmd.sel    = SEL_PAYLOAD;
                        cmd.rd_inc = 1'b1;
                        cmd.fin    = (cnt_reg == stat.nw);
                    end
                    cnt_next = cnt_reg + 1'b1;
                    if (cmd.fin)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/doeq_datapath.sv -----
// ----------------------------------------------------------------------------
// doeq_datapath
// Slot ring, event metadata and payload memories, publish staging, output reg.
// ----------------------------------------------------------------------------
`default_nettype none

module doeq_datapath
    import doeq_pkg::*;
#(
    parameter int QUEUE_DEPTH     = 64,
    parameter int MAX_EVENT_BYTES = 256,
    parameter int HEADER_BYTES    = 16
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire req_t     req,
    input  wire ctl_cmd_t cmd,
    output dp_stat_t      stat,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output rsp_t          rsp
);

    localparam int MAXP  = MAX_EVENT_BYTES - HEADER_BYTES;
    localparam int PW    = (MAXP + 7) / 8;
    localparam int NSLOT = QUEUE_DEPTH + 1;
    localparam int SLW   = $clog2(NSLOT);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int SW    = $clog2(MAX_EVENT_BYTES + 1);
    localparam int AW    = $clog2(NSLOT * PW);

    typedef struct packed {
        logic [SW-1:0]   size;
        logic [15:0]     kind;
        logic [31:0]     seq;
        logic [63:0]     stamp;
        logic [NW_W-1:0] wcnt;
    } meta_t;

    meta_t       meta_mem [NSLOT];
    logic [63:0] pay_mem  [NSLOT * PW];
    meta_t       meta_q;
    logic [63:0] pay_q;

    logic [SLW-1:0]  head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [31:0]     seq_reg, seq_next;
    logic            stage_open_reg, stage_reject_reg;
    logic [4:0]      stage_idx_reg;
    logic [NW_W-1:0] stage_wcnt_reg;
    logic [SW-1:0]   stage_total_reg;
    logic [15:0]     stage_kind_reg;
    logic [63:0]     stage_time_reg;

    logic [31:0]     budget_reg;
    logic [SW-1:0]   size_reg;
    logic [63:0]     stamp_reg;
    logic [NW_W-1:0] wcnt_reg, nw_reg;
    logic [AW-1:0]   base_reg;
    logic [NW_W-1:0] rd_idx_reg, rd_idx_next;
    logic [AW-1:0]   rd_addr;
    logic            out_valid_reg;
    rsp_t            out_reg, out_next;

    logic            pub, first, rej, wr_en, commit, drain;
    logic [SW-1:0]   total, plen, left;
    logic [NW_W-1:0] nw_in, wcnt_nx;
    logic [4:0]      idx;
    logic [15:0]     kind;
    logic [63:0]     stamp, wdata;
    logic [AW-1:0]   waddr;
    meta_t           wmeta;

    function automatic logic [SLW-1:0] slot_inc(input logic [SLW-1:0] s);
        return (s == SLW'(NSLOT - 1)) ? '0 : s + 1'b1;
    endfunction

    // ---- publish staging ----
    always_comb
    begin
        pub   = cmd.take && (req.command == CMD_PUBLISH);
        drain = cmd.take && (req.command == CMD_DRAIN);
        first = !stage_open_reg;
        rej   = first ? (req.payload_len > 16'(MAXP)) : stage_reject_reg;
        if (!first)
        begin
            total = stage_total_reg;
        end
        else if (rej)
        begin
            total = '0;
        end
        else
        begin
            total = SW'(HEADER_BYTES) + SW'(req.payload_len);
        end
        kind    = first ? req.event_type : stage_kind_reg;
        stamp   = first ? req.timestamp : stage_time_reg;
        plen    = total - SW'(HEADER_BYTES);
        nw_in   = NW_W'((plen + SW'(7)) >> 3);
        idx     = first ? 5'd0 : stage_idx_reg;
        wr_en   = pub && !rej && (NW_W'(idx) < nw_in);
        left    = plen - SW'({idx, 3'b000});
        for (int b = 0; b < 8; b++)
        begin
            // keep only bytes inside the payload length
            wdata[8*b +: 8] = (left > SW'(b)) ? req.payload_word[8*b +: 8] : 8'h00;
        end
        wcnt_nx = (first ? '0 : stage_wcnt_reg) + NW_W'(wr_en);
        waddr   = AW'(tail_reg) * AW'(PW) + AW'(idx);
        commit  = pub && req.word_last && !rej;
    end

    // ---- ring pointers ----
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        seq_next   = seq_reg;
        if (commit)
        begin
            seq_next  = seq_reg + 1'b1;
            tail_next = slot_inc(tail_reg);
            // drop the oldest event when full
            if (count_reg == CW'(QUEUE_DEPTH))
            begin
                head_next = slot_inc(head_reg);
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        if (drain)
        begin
            head_next  = tail_reg;
            count_next = '0;
        end
        if (cmd.pop)
        begin
            head_next  = slot_inc(head_reg);
            count_next = count_reg - 1'b1;
        end
    end

    assign wmeta = '{size: total, kind: kind, seq: seq_next, stamp: stamp, wcnt: wcnt_nx};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
            seq_reg          <= '0;
            stage_open_reg   <= 1'b0;
            stage_reject_reg <= 1'b0;
            stage_idx_reg    <= '0;
            stage_wcnt_reg   <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            seq_reg   <= seq_next;
            if (pub)
            begin
                if (req.word_last)
                begin
                    stage_open_reg   <= 1'b0;
                    stage_reject_reg <= 1'b0;
                    stage_idx_reg    <= '0;
                    stage_wcnt_reg   <= '0;
                end
                else
                begin
                    stage_open_reg   <= 1'b1;
                    stage_reject_reg <= rej;
                    stage_idx_reg    <= (idx == 5'd31) ? idx : idx + 1'b1;
                    stage_wcnt_reg   <= wcnt_nx;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pub && first)
        begin
            stage_total_reg <= total;
            stage_kind_reg  <= req.event_type;
            stage_time_reg  <= req.timestamp;
        end
        if (cmd.take)
        begin
            budget_reg <= req.remaining_budget;
        end
        if (cmd.rd_clr)
        begin
            size_reg  <= meta_q.size;
            stamp_reg <= meta_q.stamp;
            wcnt_reg  <= meta_q.wcnt;
            nw_reg    <= NW_W'((meta_q.size - SW'(HEADER_BYTES) + SW'(7)) >> 3);
            base_reg  <= AW'(head_reg) * AW'(PW);
        end
        rd_idx_reg <= rd_idx_next;
    end

    // ---- memories ----
    always_comb
    begin
        if (cmd.rd_clr)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.rd_inc)
        begin
            rd_idx_next = rd_idx_reg + 1'b1;
        end
        else
        begin
            rd_idx_next = rd_idx_reg;
        end
        rd_addr = (cmd.rd_clr ? AW'(head_reg) * AW'(PW) : base_reg) + AW'(rd_idx_next);
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            meta_mem[tail_reg] <= wmeta;
        end
        meta_q <= meta_mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pay_mem[waddr] <= wdata;
        end
        pay_q <= pay_mem[rd_addr];
    end

    // ---- output register ----
    always_comb
    begin
        out_next              = '0;
        out_next.word_final   = cmd.fin;
        out_next.queued_after = 7'(count_next);
        unique case (cmd.sel)
            SEL_EMPTY:
            begin
                out_next.status = ST_EMPTY;
            end
            SEL_NOFIT:
            begin
                out_next.status      = ST_NOFIT;
                out_next.event_bytes = 9'(meta_q.size);
            end
            SEL_DRAIN:
            begin
                out_next.status = ST_DRAIN;
            end
            SEL_WORD0:
            begin
                out_next.status      = ST_EVENT;
                out_next.data_word   = {meta_q.seq, meta_q.kind, 16'(meta_q.size)};
                out_next.event_bytes = 9'(meta_q.size);
            end
            SEL_WORD1:
            begin
                out_next.status      = ST_EVENT;
                out_next.data_word   = stamp_reg;
                out_next.event_bytes = 9'(size_reg);
            end
            SEL_PAYLOAD:
            begin
                // words that were never published read as zero
                out_next.status      = ST_EVENT;
                out_next.data_word   = (rd_idx_reg < wcnt_reg) ? pay_q : 64'd0;
                out_next.event_bytes = 9'(size_reg);
            end
            default:
            begin
                out_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.sel != SEL_NONE)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sel != SEL_NONE)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_valid     = out_valid_reg;
    assign rsp           = out_reg;
    assign stat.empty    = (count_reg == '0);
    assign stat.fits     = (32'(meta_q.size) <= budget_reg);
    assign stat.out_busy = out_valid_reg && !rsp_ready;
    assign stat.nw       = nw_reg;

endmodule

`default_nettype wire

// ----- rtl/drop_oldest_event_queue_core.sv -----
// Publish words: one per cycle while req_ready is high, no result.
// Drain, and pull on an empty queue: one registered result, in the next cycle.
// Pull: metadata read, fit check (no-fit result), then one word per cycle unless
// stalled: header words from metadata, payload from the memory's registered port.
// Reset (rst_n, asynchronous) empties the ring and zeroes the sequence count;
// memories are not cleared and need no sweep.
// ----------------------------------------------------------------------------
// drop_oldest_event_queue_core
// Bounded event queue that evicts the oldest event when full.
// ----------------------------------------------------------------------------
`default_nettype none

module drop_oldest_event_queue_core
    import doeq_pkg::*;
#(
    parameter int QUEUE_DEPTH     = 64,
    parameter int MAX_EVENT_BYTES = 256,
    parameter int HEADER_BYTES    = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    doeq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .command   (req.command),
        .stat      (stat),
        .cmd       (cmd)
    );

    doeq_datapath #(
        .QUEUE_DEPTH     (QUEUE_DEPTH),
        .MAX_EVENT_BYTES (MAX_EVENT_BYTES),
        .HEADER_BYTES    (HEADER_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ----- rtl/doeq_checker.sv -----
// ----------------------------------------------------------------------------
// doeq_assertions
// Port-level checks on the result channel of the event queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module doeq_assertions
    import doeq_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire rsp_t rsp
);

    `CHK_IMPLY(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, ##1 (rsp_valid && $stable(rsp)), "stalled result changed")
    `CHK_IMPLY(a_status_final, clk, rst_n, rsp_valid && rsp.status != ST_EVENT, rsp.word_final, "status result not final")
    `CHK_IMPLY(a_drain_zero, clk, rst_n, rsp_valid && rsp.status == ST_DRAIN, rsp.queued_after == 7'd0 && rsp.event_bytes == 9'd0, "drain left events")
    `CHK_IMPLY(a_empty_zero, clk, rst_n, rsp_valid && rsp.status == ST_EMPTY, rsp.queued_after == 7'd0 && rsp.data_word == 64'd0, "empty report with events")

endmodule

bind drop_oldest_event_queue_core doeq_assertions u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire
